// File: rtl/ufem_pkg.sv
`default_nettype none
package ufem_pkg;
  localparam int unsigned VidW   = 16;
  localparam int unsigned Depth  = 65536;
  localparam int unsigned NumVtx = 65536;
  localparam int unsigned SizeW  = 17;
  localparam int unsigned RankW  = 5;
  localparam int unsigned ThrW   = 25;
  localparam int unsigned CW     = 24;
  localparam int unsigned WtW    = 20;
  localparam int unsigned CntW   = 17;
  localparam logic [CntW-1:0] ActiveVtx = CntW'((NumVtx < Depth) ? NumVtx : Depth);
  localparam logic [CW-1:0] MergeCReset = CW'(102400);
  localparam logic [1:0] RegMergeC = 2'd0;
endpackage
`default_nettype wire

// File: rtl/ufem_divider.sv
`default_nettype none
// Restoring divider: one quotient bit per cycle, 24 quotient bits a transaction.
module ufem_divider
  import ufem_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CW-1:0]    dividend_i,
  input  wire logic [SizeW-1:0] divisor_i,
  output logic                  busy_o,
  output logic [CW-1:0]         quot_o
);
  logic [CW-1:0]    quot_q, quot_d;
  logic [SizeW:0]   rem_q, rem_d;
  logic [SizeW-1:0] dvs_q, dvs_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [SizeW:0]   trial;
  logic [SizeW+1:0] diff;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial  = {rem_q[SizeW-1:0], quot_q[CW-1]};
    diff   = {1'b0, trial} - {2'b0, dvs_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 5'(CW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[SizeW+1]) begin
        rem_d  = diff[SizeW:0];
        quot_d = {quot_q[CW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[CW-2:0], 1'b0};
      end
      if (cnt_q == '0) busy_d = 1'b0;
      else cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == '0 && !start_i |=> !busy_q) else $error("divider overran");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
  a_cnt_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == 5'(CW - 1)) else $error("divider count not loaded");
endmodule
`default_nettype wire

// File: rtl/union_find_edge_merge_segmenter.sv
`default_nettype none
// Sequence: after acceptance, check both vertex ids, walk each endpoint's chain to its root,
// compress a non-root endpoint onto its root, decide, and for a merge divide and write the new root.
// Throughput: one edge at a time; the next is accepted once the result register is free.
// Path depth in the forest and the serial divider set the rate.
// Reset: a clearing pass over all 65536 rows initialises the forest; no edge accepted meanwhile.
// The merge constant resets to 102400 and may be written during the clearing pass.
module union_find_edge_merge_segmenter
  import ufem_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [VidW-1:0]  vertex_a_i,
  input  wire logic [VidW-1:0]  vertex_b_i,
  input  wire logic [WtW-1:0]   weight_i,
  input  wire logic             last_edge_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  merged_o,
  output logic [VidW-1:0]       root_o,
  output logic [SizeW-1:0]      component_size_o,
  output logic [CntW-1:0]       component_count_o,
  output logic                  done_res_o
);
  localparam int unsigned EntW = VidW + RankW + SizeW + ThrW;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StRdA   = 4'd2;
  localparam logic [3:0] StChkA  = 4'd3;
  localparam logic [3:0] StRdB   = 4'd4;
  localparam logic [3:0] StChkB  = 4'd5;
  localparam logic [3:0] StDec   = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StWrTop = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StWait  = 4'd10;

  // Forest memory: one row per vertex {parent, rank, size, threshold}
  logic [EntW-1:0] mem [Depth];
  logic [EntW-1:0] rd_q;
  logic [VidW-1:0] raddr, waddr;
  logic [EntW-1:0] wdata;
  logic            we;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [VidW-1:0]  rd_par;
  logic [RankW-1:0] rd_rank;
  logic [SizeW-1:0] rd_size;
  logic [ThrW-1:0]  rd_thr;
  assign {rd_par, rd_rank, rd_size, rd_thr} = rd_q;

  logic [3:0]       st_q, st_d;
  logic [VidW-1:0]  clr_q, clr_d;
  logic [CW-1:0]    mc_q, mc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [VidW-1:0]  va_q, vb_q, cur_q, cur_d;
  logic [WtW-1:0]   w_q;
  logic             last_q;
  logic [VidW-1:0]  ra_q, ra_d, rb_q, rb_d;
  logic [RankW-1:0] rka_q, rka_d, rkb_q, rkb_d;
  logic [SizeW-1:0] sza_q, sza_d, szb_q, szb_d, szt_q, szt_d;
  logic [ThrW-1:0]  tha_q, tha_d, thb_q, thb_d;
  logic             wrq_q, wrq_d;
  logic [VidW-1:0]  top_q, top_d;
  logic [RankW-1:0] rkt_q, rkt_d;
  logic             ovld_q, ovld_d, omrg_q, omrg_d, odone_q, odone_d;
  logic [VidW-1:0]  oroot_q, oroot_d;
  logic [SizeW-1:0] osz_q, osz_d;
  logic             div_start, div_busy;
  logic [CW-1:0]    div_q;
  logic             in_acc, out_acc, cfg_wr;
  logic [ThrW-1:0]  thr_a, thr_b, sum_thr;
  logic [SizeW-1:0] sum_sz;
  logic             a_ok, b_ok;

  ufem_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(mc_q), .divisor_i(szt_q),
    .busy_o(div_busy), .quot_o(div_q)
  );

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ovld_q && !out_stall_i;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr == RegMergeC) ? {8'b0, mc_q} : 32'b0;
  assign in_stall_o = (st_q != StIdle) || ovld_q;

  // Threshold of a singleton reads as the current constant
  assign thr_a = (sza_q <= SizeW'(1)) ? ThrW'(mc_q) : tha_q;
  assign thr_b = (szb_q <= SizeW'(1)) ? ThrW'(mc_q) : thb_q;
  assign sum_sz = sza_q + szb_q;
  assign sum_thr = (szt_q == '0) ? ThrW'(w_q) + ThrW'(mc_q) : ThrW'(w_q) + ThrW'(div_q);
  assign a_ok = {1'b0, va_q} < ActiveVtx || ActiveVtx == '0;
  assign b_ok = {1'b0, vb_q} < ActiveVtx || ActiveVtx == '0;

  // Sequencer: check ids, walk both chains, compress, decide, and on a merge divide and write back
  always_comb begin
    st_d = st_q; clr_d = clr_q; mc_d = mc_q; cnt_d = cnt_q; cur_d = cur_q;
    ra_d = ra_q; rb_d = rb_q; rka_d = rka_q; rkb_d = rkb_q;
    sza_d = sza_q; szb_d = szb_q; tha_d = tha_q; thb_d = thb_q;
    szt_d = szt_q; top_d = top_q; rkt_d = rkt_q; wrq_d = wrq_q;
    ovld_d = ovld_q; omrg_d = omrg_q; oroot_d = oroot_q; osz_d = osz_q;
    odone_d = odone_q;
    raddr = cur_q; waddr = cur_q; wdata = '0; we = 1'b0; div_start = 1'b0;
    if (cfg_wr && paddr == RegMergeC) mc_d = pwdata[CW-1:0];
    if (out_acc) ovld_d = 1'b0;
    unique case (st_q)
      StClear: begin
        we = 1'b1; waddr = clr_q;
        wdata = {clr_q, RankW'(0), SizeW'(1), ThrW'(0)};
        clr_d = clr_q + VidW'(1);
        if (clr_q == '1) st_d = StIdle;
      end
      StIdle: begin
        if (in_acc) st_d = StWait;
      end
      StWait: begin
        if (!(a_ok && b_ok)) begin
          omrg_d = 1'b0; oroot_d = '0; osz_d = '0; odone_d = last_q;
          st_d = StOut;
        end else begin
          cur_d = va_q; raddr = va_q; st_d = StChkA;
        end
      end
      StRdA: begin
        raddr = cur_q; st_d = StChkA;
      end
      StChkA: begin
        if (rd_par != cur_q) begin
          cur_d = rd_par; raddr = rd_par; st_d = StChkA;
        end else begin
          ra_d = cur_q; rka_d = rd_rank; sza_d = rd_size; tha_d = rd_thr;
          // Compress the queried node onto its root
          if (va_q != cur_q) begin
            wrq_d = 1'b1; st_d = StRdB; cur_d = va_q; raddr = va_q;
          end else begin
            cur_d = vb_q; raddr = vb_q; st_d = StChkB;
          end
        end
      end
      StRdB: begin
        // Read-modify-write of vertex_a's row, then start the second walk
        if (wrq_q) begin
          we = 1'b1; waddr = va_q; wdata = {ra_q, rd_q[EntW-VidW-1:0]};
          wrq_d = 1'b0; cur_d = vb_q; raddr = vb_q;
        end else raddr = vb_q;
        st_d = wrq_q ? StRdB : StChkB;
        if (wrq_q) st_d = StRdA;
        if (wrq_q) begin cur_d = vb_q; st_d = StChkB; end
      end
      StChkB: begin
        if (rd_par != cur_q) begin
          cur_d = rd_par; raddr = rd_par;
        end else begin
          rb_d = cur_q; rkb_d = rd_rank; szb_d = rd_size; thb_d = rd_thr;
          if (vb_q != cur_q) begin
            wrq_d = 1'b1;
          end
          raddr = vb_q;
          st_d = StDec;
        end
      end
      StDec: begin
        // rd_q holds vertex_b's row when a compression write is pending
        if (wrq_q) begin
          we = 1'b1; waddr = vb_q; wdata = {rb_q, rd_q[EntW-VidW-1:0]}; wrq_d = 1'b0;
        end
        if (ra_q == rb_q) begin
          szb_d = sza_q;
        end
        if (ra_q != rb_q && {5'b0, w_q} <= thr_a && {5'b0, w_q} <= thr_b) begin
          if (rka_q > rkb_q) begin
            top_d = ra_q; rkt_d = rka_q;
            we = 1'b1; waddr = rb_q;
            wdata = {ra_q, rkb_q, szb_q, thb_q};
          end else begin
            top_d = rb_q;
            rkt_d = (rka_q == rkb_q && rkb_q < RankW'(31)) ? rkb_q + RankW'(1) : rkb_q;
            we = 1'b1; waddr = ra_q;
            wdata = {rb_q, rka_q, sza_q, tha_q};
          end
          szt_d = sum_sz; st_d = StDiv;
          div_start = 1'b0;
        end else begin
          omrg_d = 1'b0; oroot_d = ra_q; osz_d = sza_q; odone_d = last_q;
          st_d = StOut;
        end
        if (wrq_q && we && waddr != vb_q) begin
          // Two writes collide: do compression now, link next cycle
          waddr = vb_q; wdata = {rb_q, rd_q[EntW-VidW-1:0]}; wrq_d = 1'b0;
          st_d = StDec;
          szt_d = szt_q; top_d = top_q; rkt_d = rkt_q;
        end
      end
      StDiv: begin
        if (!div_busy && !wrq_q) begin
          div_start = 1'b1; wrq_d = 1'b1;
        end else if (!div_busy) begin
          wrq_d = 1'b0; st_d = StWrTop;
        end
      end
      StWrTop: begin
        we = 1'b1; waddr = top_q;
        wdata = {top_q, rkt_q, szt_q, sum_thr};
        if (cnt_q > CntW'(1)) cnt_d = cnt_q - CntW'(1);
        omrg_d = 1'b1; oroot_d = top_q; osz_d = szt_q; odone_d = last_q;
        st_d = StOut;
      end
      StOut: begin
        ovld_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // Capture the edge on acceptance; register the walk and result fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      va_q <= vertex_a_i; vb_q <= vertex_b_i; w_q <= weight_i; last_q <= last_edge_i;
    end
    cur_q <= cur_d; ra_q <= ra_d; rb_q <= rb_d; rka_q <= rka_d; rkb_q <= rkb_d;
    sza_q <= sza_d; szb_q <= szb_d; tha_q <= tha_d; thb_q <= thb_d;
    szt_q <= szt_d; top_q <= top_d; rkt_q <= rkt_d;
    omrg_q <= omrg_d; oroot_q <= oroot_d; osz_q <= osz_d; odone_q <= odone_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; mc_q <= MergeCReset; cnt_q <= ActiveVtx;
      ovld_q <= 1'b0; wrq_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; mc_q <= mc_d; cnt_q <= cnt_d;
      ovld_q <= ovld_d; wrq_q <= wrq_d;
    end
  end

  assign out_valid_o       = ovld_q;
  assign merged_o          = omrg_q;
  assign root_o            = oroot_q;
  assign component_size_o  = osz_q;
  assign component_count_o = cnt_q;
  assign done_res_o        = odone_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> st_q == StIdle) else $error("edge taken while busy");
  a_count_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0) else $error("set count reached zero");
  a_merge_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StWrTop |=> omrg_q) else $error("merge not reported");
endmodule
`default_nettype wire
